// ===== design/rwmf_pkg.sv =====
// ----------------------------------------------------------------------------
// rwmf_pkg
// Shared types, constants and helpers of the raster window mode filter.
// ----------------------------------------------------------------------------
package rwmf_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_RADIUS_DEF = 3;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RADIUS = 2'd2;

    // input item opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_PAD   = 1'b1;

    localparam logic [31:0] NEG_ZERO   = 32'h8000_0000;
    localparam logic [31:0] EXP_MASK   = 32'h7F80_0000;

    typedef struct packed {
        logic        op;
        logic [31:0] pixel_bits;
    } rwmf_in_t;

    typedef struct packed {
        logic [31:0] mode_bits;
        logic        last_pixel;
    } rwmf_out_t;

    // controls from the sequencer to the counting unit
    typedef struct packed {
        logic wr_en;
        logic wr_valid;
        logic scan_clr;
        logic scan_en;
    } rwmf_mode_ctrl_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_GATHER = 5'b00100,
        ST_SCAN   = 5'b01000,
        ST_EMIT   = 5'b10000
    } rwmf_state_t;

    // minus zero counts as plus zero
    function automatic logic [31:0] fold_zero(input logic [31:0] b);
        fold_zero = (b == NEG_ZERO) ? 32'h0 : b;
    endfunction

    // nan and infinity are never counted
    function automatic logic is_countable(input logic [31:0] b);
        is_countable = ((b & EXP_MASK) != EXP_MASK);
    endfunction

endpackage

// ===== design/raster_window_mode_filter.sv =====
// ----------------------------------------------------------------------------
// raster_window_mode_filter
// Square-window mode filter over a raster of raw single-precision pixels.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ channel in row-major order (op = pixel) and are kept
// in a line store of 2*MAX_RADIUS+1 rows. Once the whole window of the next
// pending result has arrived, the result leaves on the m_ channel holding the
// most frequent countable value of that window; last_pixel marks the final
// pixel of the image. Pad requests (op = pad) push out the trailing results.
// A request that yields no result passes through the check state and back to
// idle. When it yields one, the window is read from the line store one entry a
// cycle and then scanned by the counting unit one candidate a cycle; the result
// is then loaded into the output register once that is free, and the next
// request can be taken once the block is back in idle.
// s_ready is low while a request is worked on. A stalled receiver holds the
// result in the output register; the next request is still taken and
// processed, and only its result waits for the register to empty.
// Reset clears the counters and the registers to width 2048, height 1 and
// radius 1; configuration writes restart the image.
// ----------------------------------------------------------------------------
module raster_window_mode_filter import rwmf_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rwmf_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rwmf_out_t             m_data
);

    localparam int SIDE   = 2 * MAX_RADIUS + 1;
    localparam int SLOTS  = SIDE * SIDE;
    localparam int DEPTH  = SIDE * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int SW     = $clog2(SLOTS + 1);
    localparam int SIW    = $clog2(SLOTS);
    localparam int RW     = $clog2(SIDE);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = CW + 1;
    localparam int RADW   = $clog2(MAX_RADIUS + 1);
    localparam int CENTER = MAX_RADIUS * SIDE + MAX_RADIUS;

    rwmf_state_t state_reg, state_next;

    logic [11:0]     image_width_reg;
    logic [15:0]     image_height_reg;
    logic [1:0]      window_radius_reg;

    logic [15:0]     in_row_reg, out_row_reg;
    logic [CW-1:0]   in_col_reg, out_col_reg;
    logic [AW-1:0]   in_ptr_reg, out_ptr_reg;

    logic [SW-1:0]   gcnt_reg;
    logic [RW-1:0]   ry_reg, rx_reg;
    logic            rd_pend_reg, rd_ok_reg;
    logic [SIW-1:0]  rd_slot_reg;
    logic [31:0]     center_reg;
    logic            last_reg;

    logic            m_valid_reg;
    rwmf_out_t       m_data_reg;

    logic [WW-1:0]   w_eff;
    logic [15:0]     h_eff;
    logic [RADW-1:0] r_eff;

    logic            s_acc, pix_wr, emit_go, cfg_hit, img_done;
    logic            win_ready, is_last;
    logic [16:0]     nr;
    logic [WW:0]     nc;

    logic signed [RW+1:0] dy, dx;
    logic signed [17:0]   ypos;
    logic signed [WW+1:0] xpos;
    logic                 pos_ok;
    logic signed [AW+1:0] dy_w, w_s, prod, addr_s;
    logic [AW-1:0]        rd_addr;
    logic [31:0]          rd_data;
    logic [31:0]          best_value;
    rwmf_mode_ctrl_t      mctrl;

    // effective configuration
    always_comb begin
        if (image_width_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(image_width_reg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(image_width_reg);
        end
        h_eff = (image_height_reg == '0) ? 16'd1 : image_height_reg;
        r_eff = (32'(window_radius_reg) > MAX_RADIUS) ? RADW'(MAX_RADIUS)
                                                      : RADW'(window_radius_reg);
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign pix_wr   = s_acc && (s_data.op == OP_PIXEL) && (in_row_reg < h_eff);
    assign emit_go  = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign cfg_hit  = cfg_we && (cfg_index == CFG_IMAGE_WIDTH
                      || cfg_index == CFG_IMAGE_HEIGHT || cfg_index == CFG_WINDOW_RADIUS);
    assign img_done = emit_go && last_reg;

    // result availability and last pixel check
    always_comb begin
        nr = 17'(out_row_reg) + 17'(r_eff);
        if (nr > 17'(h_eff - 16'd1)) begin
            nr = 17'(h_eff - 16'd1);
        end
        nc = (WW+1)'(out_col_reg) + (WW+1)'(r_eff);
        if (nc > (WW+1)'(w_eff - WW'(1))) begin
            nc = (WW+1)'(w_eff - WW'(1));
        end
        win_ready = (in_row_reg >= h_eff) || (17'(in_row_reg) > nr)
                    || ((17'(in_row_reg) == nr) && ((WW+1)'(in_col_reg) > nc));
        is_last   = (out_row_reg == h_eff - 16'd1)
                    && (WW'(out_col_reg) == w_eff - WW'(1));
    end

    // window position and line store address
    always_comb begin
        dy     = (RW+2)'(ry_reg) - (RW+2)'(MAX_RADIUS);
        dx     = (RW+2)'(rx_reg) - (RW+2)'(MAX_RADIUS);
        ypos   = 18'(out_row_reg) + 18'(dy);
        xpos   = (WW+2)'(out_col_reg) + (WW+2)'(dx);
        pos_ok = (32'(ry_reg) + 32'(r_eff) >= MAX_RADIUS)
                 && (32'(ry_reg) <= MAX_RADIUS + 32'(r_eff))
                 && (32'(rx_reg) + 32'(r_eff) >= MAX_RADIUS)
                 && (32'(rx_reg) <= MAX_RADIUS + 32'(r_eff))
                 && (ypos >= 0) && (ypos < $signed({2'b00, h_eff}))
                 && (xpos >= 0) && (xpos < $signed({2'b00, w_eff}));
        dy_w   = (AW+2)'(dy);
        w_s    = (AW+2)'(w_eff);
        prod   = dy_w * w_s;
        addr_s = (AW+2)'(out_ptr_reg) + prod + (AW+2)'(dx);
        if (addr_s < 0) begin
            addr_s = addr_s + (AW+2)'(DEPTH);
        end else if (addr_s >= (AW+2)'(DEPTH)) begin
            addr_s = addr_s - (AW+2)'(DEPTH);
        end
        rd_addr = addr_s[AW-1:0];
    end

    rwmf_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (pix_wr),
        .waddr (in_ptr_reg),
        .wdata (s_data.pixel_bits),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // counting unit controls
    always_comb begin
        mctrl.wr_en    = (state_reg == ST_GATHER) && rd_pend_reg;
        mctrl.wr_valid = rd_ok_reg && is_countable(rd_data);
        mctrl.scan_clr = (state_reg == ST_GATHER) && (gcnt_reg == SW'(SLOTS));
        mctrl.scan_en  = (state_reg == ST_SCAN);
    end

    rwmf_mode_unit #(
        .SLOTS (SLOTS)
    ) u_mode_unit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (mctrl),
        .wr_slot     (rd_slot_reg),
        .wr_data     (rd_data),
        .scan_slot   (gcnt_reg[SIW-1:0]),
        .center_bits (center_reg),
        .best_value  (best_value)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = win_ready ? ST_GATHER : ST_IDLE;
            end
            ST_GATHER: begin
                if (gcnt_reg == SW'(SLOTS)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (gcnt_reg == SW'(SLOTS - 1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg   <= 12'd2048;
            image_height_reg  <= 16'd1;
            window_radius_reg <= 2'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_wdata[11:0];
                CFG_IMAGE_HEIGHT:  image_height_reg  <= cfg_wdata[15:0];
                CFG_WINDOW_RADIUS: window_radius_reg <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // input position and write pointer
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit || img_done) begin
            in_row_reg <= '0;
            in_col_reg <= '0;
            in_ptr_reg <= '0;
        end else if (pix_wr) begin
            if (WW'(in_col_reg) + WW'(1) >= w_eff) begin
                in_col_reg <= '0;
                in_row_reg <= in_row_reg + 16'd1;
            end else begin
                in_col_reg <= in_col_reg + CW'(1);
            end
            in_ptr_reg <= (in_ptr_reg == AW'(DEPTH - 1)) ? '0 : in_ptr_reg + AW'(1);
        end
    end

    // output position and read base pointer
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit || img_done) begin
            out_row_reg <= '0;
            out_col_reg <= '0;
            out_ptr_reg <= '0;
        end else if (emit_go) begin
            if (WW'(out_col_reg) + WW'(1) >= w_eff) begin
                out_col_reg <= '0;
                out_row_reg <= out_row_reg + 16'd1;
            end else begin
                out_col_reg <= out_col_reg + CW'(1);
            end
            out_ptr_reg <= (out_ptr_reg == AW'(DEPTH - 1)) ? '0 : out_ptr_reg + AW'(1);
        end
    end

    // window sweep counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gcnt_reg    <= '0;
            ry_reg      <= '0;
            rx_reg      <= '0;
            rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= 1'b0;
            priority case (1'b1)
                (state_reg == ST_CHECK): begin
                    gcnt_reg <= '0;
                    ry_reg   <= '0;
                    rx_reg   <= '0;
                    last_reg <= is_last;
                end
                (state_reg == ST_GATHER): begin
                    if (gcnt_reg == SW'(SLOTS)) begin
                        gcnt_reg <= '0;
                    end else begin
                        gcnt_reg    <= gcnt_reg + SW'(1);
                        rd_pend_reg <= 1'b1;
                        rd_slot_reg <= gcnt_reg[SIW-1:0];
                        rd_ok_reg   <= pos_ok;
                        if (rx_reg == RW'(SIDE - 1)) begin
                            rx_reg <= '0;
                            ry_reg <= ry_reg + RW'(1);
                        end else begin
                            rx_reg <= rx_reg + RW'(1);
                        end
                    end
                end
                (state_reg == ST_SCAN): begin
                    gcnt_reg <= gcnt_reg + SW'(1);
                end
                default: ;
            endcase
        end
    end

    // centre pixel capture
    always_ff @(posedge aclk) begin
        if (mctrl.wr_en && (rd_slot_reg == SIW'(CENTER))) begin
            center_reg <= rd_data;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_go) begin
            m_data_reg.mode_bits  <= best_value;
            m_data_reg.last_pixel <= last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/rwmf_ram.sv =====
// ----------------------------------------------------------------------------
// rwmf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rwmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rwmf_mode_unit.sv =====
// ----------------------------------------------------------------------------
// rwmf_mode_unit
// Window registers and the shared counting unit: one candidate per cycle is
// compared against every window entry and the best count is kept.
// ----------------------------------------------------------------------------
module rwmf_mode_unit import rwmf_pkg::*; #(
    parameter int SLOTS = 49
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  rwmf_mode_ctrl_t          ctrl,
    input  logic [$clog2(SLOTS)-1:0] wr_slot,
    input  logic [31:0]              wr_data,
    input  logic [$clog2(SLOTS)-1:0] scan_slot,
    input  logic [31:0]              center_bits,
    output logic [31:0]              best_value
);

    localparam int CNT_W = $clog2(SLOTS + 1);

    logic [31:0]      win_reg [SLOTS];
    logic [SLOTS-1:0] win_valid_reg;
    logic [31:0]      best_value_reg;
    logic [CNT_W-1:0] best_count_reg;
    logic [SLOTS-1:0] match;
    logic [31:0]      cand_key;
    logic [CNT_W-1:0] cand_count;

    // compare the candidate with all entries
    always_comb begin
        cand_key = fold_zero(win_reg[scan_slot]);
        for (int j = 0; j < SLOTS; j++) begin
            match[j] = win_valid_reg[j] && (fold_zero(win_reg[j]) == cand_key);
        end
        cand_count = CNT_W'($countones(match));
    end

    // window entry load
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            win_reg[wr_slot] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_valid_reg <= '0;
        end else if (ctrl.wr_en) begin
            win_valid_reg[wr_slot] <= ctrl.wr_valid;
        end
    end

    // best candidate, first occurrence wins ties
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_value_reg <= '0;
            best_count_reg <= '0;
        end else if (ctrl.scan_clr) begin
            best_value_reg <= center_bits;
            best_count_reg <= '0;
        end else if (ctrl.scan_en && win_valid_reg[scan_slot]
                     && (cand_count > best_count_reg)) begin
            best_value_reg <= win_reg[scan_slot];
            best_count_reg <= cand_count;
        end
    end

    assign best_value = best_value_reg;

endmodule

// ===== tb/raster_window_mode_filter_test.sv =====
// ----------------------------------------------------------------------------
// raster_window_mode_filter_test
// Self-checking bench for the square-window mode filter.
// ----------------------------------------------------------------------------
// Small images are streamed through the block under several register settings,
// including the size extremes. A behavioural mode filter in the bench works out
// each result, and the results are checked in order against it. Both channels
// idle and stall at random in phases.
// ----------------------------------------------------------------------------
module raster_window_mode_filter_test;
    import rwmf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE  = 2 * MAX_RADIUS_DEF + 1;
    localparam int DEPTH = SIDE * MAX_WIDTH_DEF;
    localparam int LIMIT = 3000000;

    // index past the register list
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_taken = 1'b0;
    rwmf_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rwmf_out_t m_data;

    raster_window_mode_filter DUT (.*);

    // predictor state
    logic [31:0] pix_store [DEPTH];
    int unsigned img_w = 2048, img_h = 1, win_r = 1;
    int unsigned in_r, in_c, out_r, out_c;

    rwmf_in_t  pending_reqs [$];
    rwmf_out_t modes_due [$];
    int send_idle_pct = 0, recv_stall_pct = 0;
    int errors = 0, cycles = 0, n_results = 0, n_reqs = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [31:0] zfold(logic [31:0] b);
        return (b == 32'h8000_0000) ? 32'h0 : b;
    endfunction

    function automatic void clear_counts();
        in_r = 0;
        in_c = 0;
        out_r = 0;
        out_c = 0;
    endfunction

    function automatic logic [31:0] window_mode(int unsigned r, int unsigned c);
        logic [31:0] vals [SIDE*SIDE];
        logic [31:0] best;
        int n, cnt, best_cnt, y, x;
        n = 0;
        best_cnt = 0;
        for (int dy = -int'(win_r); dy <= int'(win_r); dy++) begin
            y = int'(r) + dy;
            if (y < 0 || y >= int'(img_h)) continue;
            for (int dx = -int'(win_r); dx <= int'(win_r); dx++) begin
                x = int'(c) + dx;
                if (x < 0 || x >= int'(img_w)) continue;
                vals[n] = pix_store[(y * img_w + x) % DEPTH];
                if ((vals[n] & EXP_MASK) != EXP_MASK) n++;
            end
        end
        best = pix_store[(r * img_w + c) % DEPTH];
        for (int i = 0; i < n; i++) begin
            cnt = 0;
            for (int j = 0; j < n; j++)
                if (zfold(vals[j]) == zfold(vals[i])) cnt++;
            if (cnt > best_cnt) begin
                best_cnt = cnt;
                best = vals[i];
            end
        end
        return best;
    endfunction

    // advance the predictor by one accepted request
    function automatic void predict_mode(rwmf_in_t req);
        int unsigned nr, nc;
        rwmf_out_t res;
        if (req.op == OP_PIXEL && in_r < img_h) begin
            pix_store[(in_r * img_w + in_c) % DEPTH] = req.pixel_bits;
            in_c++;
            if (in_c >= img_w) begin
                in_c = 0;
                in_r++;
            end
        end
        if (out_r >= img_h) return;
        nr = (out_r + win_r > img_h - 1) ? img_h - 1 : out_r + win_r;
        nc = (out_c + win_r > img_w - 1) ? img_w - 1 : out_c + win_r;
        if (!(in_r >= img_h || in_r > nr || (in_r == nr && in_c > nc))) return;
        res.mode_bits  = window_mode(out_r, out_c);
        res.last_pixel = (out_r == img_h - 1) && (out_c == img_w - 1);
        modes_due.push_back(res);
        out_c++;
        if (out_c >= img_w) begin
            out_c = 0;
            out_r++;
        end
        if (out_r >= img_h) clear_counts();
    endfunction

    // request driver
    always @(negedge aclk) begin
        if (!s_valid || s_taken) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_data  <= pending_reqs.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // acceptance and result monitor
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            predict_mode(s_data);
            n_reqs <= n_reqs + 1;
        end
        if (aresetn && m_valid && m_ready) begin
            n_results <= n_results + 1;
            if (modes_due.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h/%0b", $time,
                         m_data.mode_bits, m_data.last_pixel);
                errors <= errors + 1;
            end else if (m_data !== modes_due[0]) begin
                $display("%0t mismatch: expected %h/%0b actual %h/%0b", $time,
                         modes_due[0].mode_bits, modes_due[0].last_pixel,
                         m_data.mode_bits, m_data.last_pixel);
                errors <= errors + 1;
                void'(modes_due.pop_front());
            end else begin
                void'(modes_due.pop_front());
            end
        end
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // wait until driver and predictor are drained
    task automatic drain();
        while (pending_reqs.size() > 0 || s_valid || modes_due.size() > 0)
            @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        // predictor takes the write at once
        case (idx)
            CFG_IMAGE_WIDTH: begin
                img_w = (val[11:0] == 12'd0) ? 1 : int'(val[11:0]);
                if (img_w > MAX_WIDTH_DEF) img_w = MAX_WIDTH_DEF;
                clear_counts();
            end
            CFG_IMAGE_HEIGHT: begin
                img_h = (val == 16'd0) ? 1 : int'(val);
                clear_counts();
            end
            CFG_WINDOW_RADIUS: begin
                win_r = val[1:0];
                if (win_r > MAX_RADIUS_DEF) win_r = MAX_RADIUS_DEF;
                clear_counts();
            end
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_pixel();
        // small palette so that modes and ties are common
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h0000_0000;
            2: return 32'h7F80_0000 | $urandom_range(1);
            3: return 32'hFF80_0000 | ($urandom & 32'h007F_FFFF);
            4: return $urandom;
            default: return 32'h3F80_0000 + $urandom_range(3);
        endcase
    endfunction

    // one whole image, sometimes with stray pads or extra pixels
    task automatic queue_image(int unsigned w, int unsigned h);
        rwmf_in_t req;
        for (int unsigned i = 0; i < w * h; i++) begin
            if ($urandom_range(19) == 0) begin
                req.op = OP_PAD;
                req.pixel_bits = $urandom;
                pending_reqs.push_back(req);
            end
            req.op = OP_PIXEL;
            req.pixel_bits = rand_pixel();
            pending_reqs.push_back(req);
        end
        for (int i = 0; i < 3 * SIDE + 2; i++) begin
            req.op = ($urandom_range(7) == 0) ? OP_PIXEL : OP_PAD;
            req.pixel_bits = $urandom;
            pending_reqs.push_back(req);
        end
    endtask

    initial begin
        int unsigned w, h, sent;
        rwmf_in_t req;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: tiny images, radius extremes, special values
        write_reg(CFG_IMAGE_WIDTH, 16'd3);
        write_reg(CFG_IMAGE_HEIGHT, 16'd3);
        write_reg(CFG_WINDOW_RADIUS, 16'd0);
        begin
            logic [31:0] dir [9] = '{32'h8000_0000, 32'h0, 32'h7FC0_0000,
                32'hFF80_0000, 32'hFFFF_FFFF, 32'h7F80_0000, 32'h0,
                32'h8000_0000, 32'h3F80_0000};
            for (int k = 0; k < 2; k++) begin
                foreach (dir[i]) begin
                    req.op = OP_PIXEL;
                    req.pixel_bits = dir[i];
                    pending_reqs.push_back(req);
                end
                for (int i = 0; i < 4; i++) begin
                    req.op = OP_PAD;
                    req.pixel_bits = 32'hFFFF_FFFF;
                    pending_reqs.push_back(req);
                end
                drain();
                write_reg(CFG_WINDOW_RADIUS, 16'd3);
            end
        end
        write_reg(CFG_IMAGE_WIDTH, 16'd1);
        write_reg(CFG_IMAGE_HEIGHT, 16'd0);
        queue_image(1, 1);
        drain();
        // widest row, only its start is sent before the image is abandoned
        write_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
        write_reg(CFG_IMAGE_HEIGHT, 16'd1);
        write_reg(CFG_WINDOW_RADIUS, 16'd2);
        for (int i = 0; i < 60; i++) begin
            req.op = OP_PIXEL;
            req.pixel_bits = rand_pixel();
            pending_reqs.push_back(req);
        end
        drain();
        write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
        for (int i = 0; i < 40; i++) begin
            req.op = OP_PIXEL;
            req.pixel_bits = (i % 2) ? 32'hFFFF_FFFF : 32'h0;
            pending_reqs.push_back(req);
        end
        drain();
        // unused register index is ignored by the block
        write_reg(CFG_SPARE_IDX, 16'hFFFF);

        // random images across idling phases
        sent = 0;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            write_reg(CFG_WINDOW_RADIUS, 16'($urandom_range(3)));
            w = $urandom_range(1, 9);
            h = $urandom_range(1, 8);
            write_reg(CFG_IMAGE_WIDTH, 16'(w));
            write_reg(CFG_IMAGE_HEIGHT, 16'(h));
            while (sent < 65 * (ph + 1)) begin
                queue_image(w, h);
                sent += w * h + 3 * SIDE;
                if (ph == 3) drain();
            end
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        $display("%0d requests accepted, %0d results checked, %0d errors",
                 n_reqs, n_results, errors);
        $display("images up to 2048 wide, radius 0..3, signed zero, nan/inf, ties");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
